### design/gsec_pkg.sv
// shared constants, types and helpers for the grid segment endpoint clip unit
`timescale 1ns / 1ps
`default_nettype none
package gsec_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIM_W      = 15;
	localparam int PROD_W     = 2 * COORD_BITS;
	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	// one interpolation in flight through the divider chain
	typedef struct packed {
		logic signed [COORD_BITS-1:0] a0;
		logic signed [COORD_BITS-1:0] b0;
		logic signed [COORD_BITS-1:0] a_new;
		logic signed [COORD_BITS-1:0] b_cur;
		logic                         act;
		logic                         neg;
		logic [PROD_W-1:0]            dvd;
		logic [PROD_W-1:0]            quot;
		logic [COORD_BITS:0]          rem;
		logic [COORD_BITS-1:0]        den;
	} job_t;

	// clamp limit from a grid size: zero acts as one, capped to the coordinate range
	function automatic logic [COORD_BITS-1:0] lim_of(input logic [DIM_W-1:0] size);
		logic [DIM_W-1:0] sm1;
		logic [64:0]      wide;
		sm1  = (size == '0) ? '0 : size - DIM_W'(1);
		wide = 65'(sm1);
		if (wide > 65'(COORD_MAX))
			return COORD_MAX;
		return COORD_BITS'(wide);
	endfunction

endpackage
`default_nettype wire

### design/gsec_div_cell.sv
// one restoring divider cell: produces one quotient bit per cycle while en is high
`timescale 1ns / 1ps
`default_nettype none
module gsec_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire gsec_pkg::job_t in_job,
	output logic               out_valid,
	output gsec_pkg::job_t     out_job
);
	localparam int W = gsec_pkg::COORD_BITS;

	logic [W:0]     r2;
	logic           ge;
	gsec_pkg::job_t nxt;

	always_comb begin
		r2  = {in_job.rem[W-1:0], in_job.dvd[gsec_pkg::PROD_W-1]};
		ge  = r2 >= {1'b0, in_job.den};
		nxt = in_job;
		nxt.rem  = ge ? (r2 - {1'b0, in_job.den}) : r2;
		nxt.dvd  = {in_job.dvd[gsec_pkg::PROD_W-2:0], 1'b0};
		nxt.quot = {in_job.quot[gsec_pkg::PROD_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_job <= nxt;
		end
	end
endmodule
`default_nettype wire

### design/gsec_pass.sv
// one clamp pass: clamp axis a, interpolate axis b through a chain of divider cells
`timescale 1ns / 1ps
`default_nettype none
module gsec_pass (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic signed [gsec_pkg::COORD_BITS-1:0] a0,
	input  wire logic signed [gsec_pkg::COORD_BITS-1:0] b0,
	input  wire logic signed [gsec_pkg::COORD_BITS-1:0] a1,
	input  wire logic signed [gsec_pkg::COORD_BITS-1:0] b1,
	input  wire logic        [gsec_pkg::COORD_BITS-1:0] lim,
	output logic                                        out_valid,
	output logic signed      [gsec_pkg::COORD_BITS-1:0] a0_out,
	output logic signed      [gsec_pkg::COORD_BITS-1:0] b0_out,
	output logic signed      [gsec_pkg::COORD_BITS-1:0] a_out,
	output logic signed      [gsec_pkg::COORD_BITS-1:0] b_out
);
	localparam int W  = gsec_pkg::COORD_BITS;
	localparam int PW = gsec_pkg::PROD_W;
	localparam int NC = PW;

	logic                  outside;
	logic signed [W-1:0]   c;
	logic signed [W:0]     den_d, num_d, oth_d;
	logic [W-1:0]          den_m, num_m, oth_m;
	gsec_pkg::job_t        job_s1;
	logic                  valid_s1;

	always_comb begin
		outside = a1[W-1] || ($unsigned(a1) > lim);
		c       = a1[W-1] ? '0 : $signed(lim);
		den_d   = (W+1)'(a1) - (W+1)'(a0);
		num_d   = (W+1)'(c) - (W+1)'(a0);
		oth_d   = (W+1)'(b1) - (W+1)'(b0);
		den_m   = W'(den_d[W] ? -den_d : den_d);
		num_m   = W'(num_d[W] ? -num_d : num_d);
		oth_m   = W'(oth_d[W] ? -oth_d : oth_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1.a0    <= a0;
			job_s1.b0    <= b0;
			job_s1.a_new <= outside ? c : a1;
			job_s1.b_cur <= b1;
			job_s1.act   <= outside && (den_d != '0);
			job_s1.neg   <= num_d[W] ^ oth_d[W] ^ den_d[W];
			job_s1.dvd   <= PW'(num_m) * PW'(oth_m);
			job_s1.quot  <= '0;
			job_s1.rem   <= '0;
			job_s1.den   <= den_m;
		end
	end

	gsec_pkg::job_t chain_job [NC+1];
	logic           chain_vld [NC+1];

	assign chain_job[0] = job_s1;
	assign chain_vld[0] = valid_s1;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		gsec_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (chain_vld[i]),
			.in_job   (chain_job[i]),
			.out_valid(chain_vld[i+1]),
			.out_job  (chain_job[i+1])
		);
	end

	// round half away from zero, apply sign, saturate
	gsec_pkg::job_t       fj;
	logic                 rnd;
	logic [PW:0]          qr;
	logic signed [PW+2:0] sum;
	logic signed [W-1:0]  sat;

	always_comb begin
		fj  = chain_job[NC];
		rnd = (fj.rem != '0) && ({fj.rem, 1'b0} >= (W+2)'(fj.den));
		qr  = (PW+1)'(fj.quot) + (PW+1)'(rnd);
		sum = fj.neg ? ((PW+3)'(fj.b0) - $signed((PW+3)'(qr)))
		             : ((PW+3)'(fj.b0) + $signed((PW+3)'(qr)));
		if (sum > $signed((PW+3)'(gsec_pkg::COORD_MAX)))
			sat = $signed(gsec_pkg::COORD_MAX);
		else if (sum < -$signed((PW+3)'(gsec_pkg::COORD_MAX)) - 1)
			sat = $signed(~gsec_pkg::COORD_MAX);
		else
			sat = W'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain_vld[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a0_out <= fj.a0;
			b0_out <= fj.b0;
			a_out  <= fj.a_new;
			b_out  <= fj.act ? sat : fj.b_cur;
		end
	end
endmodule
`default_nettype wire

### design/grid_segment_endpoint_clip_unit.sv
// top level: clamps a segment end point onto the grid, x pass then y pass
//
// channel  direction  handshake         payload
// s_axis   in         tvalid / tready   start_x, start_y, end_x, end_y
// m_axis   out        tvalid / tready   clipped_x, clipped_y
// cfg      in         we                index, data (grid_width, grid_height)
//
// one item per cycle while the output is not stalled; the two passes each hold an input
// register, a chain of one-bit divider cells and an output register.
// reset clears all valid bits; limits return to 1023 (grid of 1024).
// the whole chain advances together; it stalls only when the output register is
// full and not taken, so s_tready = !m_tvalid || m_tready.
`timescale 1ns / 1ps
`default_nettype none
module grid_segment_endpoint_clip_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// start_x, start_y, end_x, end_y from bit 0 up
	input  wire logic [4*gsec_pkg::COORD_BITS-1:0]   s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// clipped_x, clipped_y from bit 0 up
	output logic      [2*gsec_pkg::COORD_BITS-1:0]   m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [gsec_pkg::DIM_W-1:0]          cfg_data
);
	localparam int W = gsec_pkg::COORD_BITS;

	logic [W-1:0] xlim_q, ylim_q;
	logic         en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlim_q <= gsec_pkg::lim_of(gsec_pkg::DIM_RESET);
			ylim_q <= gsec_pkg::lim_of(gsec_pkg::DIM_RESET);
		end else if (cfg_we) begin
			unique case (gsec_pkg::reg_idx_t'(cfg_index))
				gsec_pkg::REG_GRID_WIDTH:  xlim_q <= gsec_pkg::lim_of(cfg_data);
				gsec_pkg::REG_GRID_HEIGHT: ylim_q <= gsec_pkg::lim_of(cfg_data);
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                vx;
	logic signed [W-1:0] x0_x, y0_x, x1_x, y1_x;
	logic signed [W-1:0] y0_y, x0_y, y1_y, x1_y;

	gsec_pass u_pass_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.a0       (s_tdata[W-1:0]),
		.b0       (s_tdata[2*W-1:W]),
		.a1       (s_tdata[3*W-1:2*W]),
		.b1       (s_tdata[4*W-1:3*W]),
		.lim      (xlim_q),
		.out_valid(vx),
		.a0_out   (x0_x),
		.b0_out   (y0_x),
		.a_out    (x1_x),
		.b_out    (y1_x)
	);

	gsec_pass u_pass_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vx),
		.a0       (y0_x),
		.b0       (x0_x),
		.a1       (y1_x),
		.b1       (x1_x),
		.lim      (ylim_q),
		.out_valid(m_tvalid),
		.a0_out   (y0_y),
		.b0_out   (x0_y),
		.a_out    (y1_y),
		.b_out    (x1_y)
	);

	logic unused_starts;
	assign unused_starts = ^{y0_y, x0_y};

	assign m_tdata = {y1_y, x1_y};
endmodule
`default_nettype wire

### design/gsec_checker.sv
// port-level checks for the grid segment endpoint clip unit
`timescale 1ns / 1ps
`default_nettype none
module gsec_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic [4*gsec_pkg::COORD_BITS-1:0] s_tdata,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [2*gsec_pkg::COORD_BITS-1:0] m_tdata
);
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// input side only stalls when the output register is full and not taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	// y of every result is clamped into the grid, so never negative
	a_y_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[2*gsec_pkg::COORD_BITS-1])
		else $error("clipped y negative");

	logic unused_in;
	assign unused_in = ^{s_tvalid, s_tdata};
endmodule

bind grid_segment_endpoint_clip_unit gsec_checker u_gsec_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
